// ----- rtl/core/stft_pkg.sv -----
// ----------------------------------------------------------------------------
// stft_pkg
// Shared constants, types and twiddle table builder for the STFT core.
// ----------------------------------------------------------------------------
package stft_pkg;

	localparam int N_FFT   = 64;                 // power of two, 4..64
	localparam int N_W     = $clog2(N_FFT);
	localparam int BIN_W   = 6;
	localparam int LAST_BIN = N_FFT / 2;
	localparam int HOP_W   = 7;
	localparam int SMP_W   = 16;
	localparam int TW_W    = 32;
	localparam int FRAC    = 29;
	localparam int PROD_W  = SMP_W + TW_W;
	localparam int ACC_W   = PROD_W + N_W;
	localparam int R8_W    = 32;
	localparam int SQ_W    = 62;
	localparam int M8_W    = 32;
	localparam int QUO_W   = 17;
	localparam int NUM_W   = 48;
	localparam int REM_W   = 33;
	localparam int MAG_W   = 22;
	localparam int PH_W    = 16;
	localparam int FRM_W   = 16;
	localparam int DATA_W  = 80;
	localparam logic [HOP_W-1:0] HOP_RESET = 7'd16;
	localparam longint PI_Q29 = 64'sd1686629713;

	typedef logic signed [TW_W-1:0] tw_tab_t [N_FFT];

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_MAC   = 9'b000000010,
		ST_DRAIN = 9'b000000100,
		ST_SQR   = 9'b000001000,
		ST_SQRT  = 9'b000010000,
		ST_MAG   = 9'b000100000,
		ST_DIV   = 9'b001000000,
		ST_FIN   = 9'b010000000,
		ST_EMIT  = 9'b100000000
	} state_t;

	// round-half-up product in Q29, operands nonnegative
	function automatic longint mul_q(input longint a, input longint b);
		return (a * b + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
	endfunction

	// shift-and-subtract quotient, operands nonnegative
	function automatic longint div_u(input longint n, input longint d);
		longint r, q;
		int     b;
		r = 0;
		q = 0;
		for (b = 62; b >= 0; b--) begin
			r = (r <<< 1) | ((n >>> b) & 64'sd1);
			if (r >= d) begin
				r = r - d;
				q = q | (64'sd1 <<< b);
			end
		end
		return q;
	endfunction

	// cosine table, or negated sine table, of 2*pi*k/N in Q29
	function automatic tw_tab_t build_tab(input logic want_sin);
		tw_tab_t t;
		longint th, x2, tc, ts, sc, ss, dc, ds, c, s;
		int     q, rho, i, k;
		for (k = 0; k < N_FFT; k++) begin
			q   = (4 * k) / N_FFT;
			rho = 4 * k - q * N_FFT;
			th  = (PI_Q29 * longint'(rho) + N_FFT) / (2 * N_FFT);
			x2  = mul_q(th, th);
			tc  = 64'sd1 <<< FRAC;
			ts  = th;
			sc  = tc;
			ss  = th;
			for (i = 1; i <= 10; i++) begin
				dc = longint'((2 * i - 1) * (2 * i));
				ds = longint'((2 * i) * (2 * i + 1));
				tc = div_u(mul_q(tc, x2) + (dc >>> 1), dc);
				ts = div_u(mul_q(ts, x2) + (ds >>> 1), ds);
				if (i % 2 == 1) begin
					sc = sc - tc;
					ss = ss - ts;
				end else begin
					sc = sc + tc;
					ss = ss + ts;
				end
			end
			case (q % 4)
				0: begin c = sc;  s = ss;  end
				1: begin c = -ss; s = sc;  end
				2: begin c = -sc; s = -ss; end
				default: begin c = ss; s = -sc; end
			endcase
			t[k] = want_sin ? TW_W'(-s) : TW_W'(c);
		end
		return t;
	endfunction

endpackage

// ----- rtl/core/stft_magnitude_phase_core.sv -----
// ----------------------------------------------------------------------------
// stft_magnitude_phase_core
// Sliding-frame DFT of a sample stream with magnitude and unit phase per bin.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  s_*      | in  | s_tvalid/s_tready  | s_tdata: sample
//  m_*      | out | m_tvalid/m_tready  | m_tdata: bin, magnitude, phases, frame;
//           |     |                    | m_tlast: last bin of frame
//  cfg_*    | in  | cfg_we             | cfg_wdata: hop size
//
// A sample that completes no frame leaves s_tready high; one that completes a
// frame keeps s_tready low while the 33 bins run in turn: 128 passes through
// the one 16x32 multiplier, a drain, squaring, 31 root steps, a magnitude check,
// then two 17-step divides with a finish step each, then an emit. The divides
// are skipped when the magnitude rounds to zero.
// Stalls on m_tready hold the sequencer in its emit step; arst_n clears control.
module stft_magnitude_phase_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [stft_pkg::SMP_W-1:0]    s_tdata,   // [15:0] sample
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [5:0] bin_index, [27:6] magnitude, [43:28] phase_re, [59:44] phase_im,
	// [75:60] frame_number, [79:76] zero
	output logic [stft_pkg::DATA_W-1:0]   m_tdata,
	output logic                          m_tlast,
	input  logic                          cfg_we,
	input  logic [stft_pkg::HOP_W-1:0]    cfg_wdata  // [6:0] hop size
);

	localparam stft_pkg::tw_tab_t COS_TAB  = stft_pkg::build_tab(1'b0);
	localparam stft_pkg::tw_tab_t NSIN_TAB = stft_pkg::build_tab(1'b1);
	localparam int OP_W = stft_pkg::N_W + 1;

	stft_pkg::state_t state_q;

	logic [stft_pkg::HOP_W-1:0]  hop_len_q, fill_q, hop_q;
	logic [stft_pkg::N_W-1:0]    ptr_q, k_q;
	logic [stft_pkg::FRM_W-1:0]  frame_q;
	logic [stft_pkg::BIN_W-1:0]  bin_q;
	logic [OP_W-1:0]             op_q;
	logic [4:0]                  cnt_q;
	logic                        part_q;

	logic signed [stft_pkg::SMP_W-1:0]  ring_q [stft_pkg::N_FFT];
	logic signed [stft_pkg::SMP_W-1:0]  x_s1;
	logic signed [stft_pkg::TW_W-1:0]   tw_s1;
	logic                               vld_s1, im_s1, vld_s2, im_s2;
	logic signed [stft_pkg::PROD_W-1:0] prod_s2;
	logic signed [stft_pkg::ACC_W-1:0]  acc_re_q, acc_im_q;
	logic                               acc_clr;

	logic signed [stft_pkg::R8_W-1:0] re8_q, im8_q;
	logic [stft_pkg::SQ_W-1:0]        sq_q, sum_q, v_q, res_q, bit_q, sq_try;
	logic [stft_pkg::M8_W-1:0]        m8;
	logic [stft_pkg::REM_W-1:0]       rem_q;
	logic [stft_pkg::QUO_W-1:0]       quo_q;
	logic [stft_pkg::REM_W:0]         div_try;
	logic [stft_pkg::PH_W-1:0]        ph_re_q, ph_im_q, ph_sat;
	logic [stft_pkg::NUM_W-1:0]       num_re, num_im;
	logic signed [stft_pkg::R8_W-1:0] re8_c, im8_c;

	logic                        in_acc, frame_go, out_load;
	logic [stft_pkg::HOP_W-1:0]  fill_nxt, hop_nxt;
	logic [stft_pkg::N_W-1:0]    rd_addr;

	logic [stft_pkg::DATA_W-1:0] out_data_q;
	logic                        out_valid_q, out_last_q;

	function automatic logic signed [stft_pkg::R8_W-1:0] round_q8(
		input logic signed [stft_pkg::ACC_W-1:0] acc);
		logic [stft_pkg::ACC_W-1:0] a;
		logic [stft_pkg::ACC_W-1:0] r;
		a = acc[stft_pkg::ACC_W-1] ? stft_pkg::ACC_W'(-acc) : stft_pkg::ACC_W'(acc);
		r = (a + (stft_pkg::ACC_W'(1) << 20)) >> 21;
		return acc[stft_pkg::ACC_W-1] ? -stft_pkg::R8_W'(r) : stft_pkg::R8_W'(r);
	endfunction

	function automatic logic [stft_pkg::NUM_W-1:0] div_num(
		input logic signed [stft_pkg::R8_W-1:0] v, input logic [stft_pkg::M8_W-1:0] m);
		logic [stft_pkg::R8_W-1:0] a;
		a = v[stft_pkg::R8_W-1] ? stft_pkg::R8_W'(-v) : stft_pkg::R8_W'(v);
		return (stft_pkg::NUM_W'(a) << 15) + stft_pkg::NUM_W'(m >> 1);
	endfunction

	assign s_tready = (state_q == stft_pkg::ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign fill_nxt = fill_q + 1'b1;
	assign hop_nxt  = hop_q + 1'b1;
	assign frame_go = (fill_q < stft_pkg::HOP_W'(stft_pkg::N_FFT))
		? (fill_nxt == stft_pkg::HOP_W'(stft_pkg::N_FFT)) : (hop_nxt >= hop_len_q);
	assign rd_addr  = ptr_q + op_q[OP_W-1:1];
	assign out_load = (state_q == stft_pkg::ST_EMIT) && (!out_valid_q || m_tready);
	assign acc_clr  = (in_acc && frame_go)
		|| (out_load && bin_q != stft_pkg::BIN_W'(stft_pkg::LAST_BIN));

	assign re8_c  = round_q8(acc_re_q);
	assign im8_c  = round_q8(acc_im_q);
	assign m8     = res_q[stft_pkg::M8_W-1:0];
	assign num_re = div_num(re8_q, m8);
	assign num_im = div_num(im8_q, m8);
	assign sq_try = res_q + bit_q;
	// quotient bits shift into quo_q as the numerator bits shift out
	assign div_try = {rem_q, quo_q[stft_pkg::QUO_W-1]};

	always_comb begin
		logic neg;
		neg = part_q ? im8_q[stft_pkg::R8_W-1] : re8_q[stft_pkg::R8_W-1];
		if (neg) begin
			ph_sat = (quo_q > stft_pkg::QUO_W'(32768)) ? 16'h8000 : stft_pkg::PH_W'(-quo_q);
		end else begin
			ph_sat = (quo_q > stft_pkg::QUO_W'(32767)) ? 16'h7fff : stft_pkg::PH_W'(quo_q);
		end
	end

	// sample ring, MAC operand fetch and product register
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ring_q[ptr_q] <= s_tdata;
		end
		x_s1    <= ring_q[rd_addr];
		tw_s1   <= op_q[0] ? NSIN_TAB[k_q] : COS_TAB[k_q];
		prod_s2 <= x_s1 * tw_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			im_s1    <= 1'b0;
			vld_s2   <= 1'b0;
			im_s2    <= 1'b0;
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else begin
			vld_s1 <= (state_q == stft_pkg::ST_MAC);
			im_s1  <= op_q[0];
			vld_s2 <= vld_s1;
			im_s2  <= im_s1;
			if (acc_clr) begin
				acc_re_q <= '0;
				acc_im_q <= '0;
			end else if (vld_s2) begin
				if (im_s2) begin
					acc_im_q <= acc_im_q + stft_pkg::ACC_W'(prod_s2);
				end else begin
					acc_re_q <= acc_re_q + stft_pkg::ACC_W'(prod_s2);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hop_len_q <= stft_pkg::HOP_RESET;
		end else if (cfg_we) begin
			hop_len_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stft_pkg::ST_IDLE;
			fill_q  <= '0;
			hop_q   <= '0;
			ptr_q   <= '0;
			frame_q <= '0;
			bin_q   <= '0;
			op_q    <= '0;
			k_q     <= '0;
			cnt_q   <= '0;
			part_q  <= 1'b0;
			re8_q   <= '0;
			im8_q   <= '0;
			sq_q    <= '0;
			sum_q   <= '0;
			v_q     <= '0;
			res_q   <= '0;
			bit_q   <= '0;
			rem_q   <= '0;
			quo_q   <= '0;
			ph_re_q <= '0;
			ph_im_q <= '0;
		end else begin
			case (state_q)
				stft_pkg::ST_IDLE: begin
					if (in_acc) begin
						ptr_q <= ptr_q + 1'b1;
						if (fill_q < stft_pkg::HOP_W'(stft_pkg::N_FFT)) begin
							fill_q <= fill_nxt;
						end
						if (frame_go) begin
							hop_q   <= '0;
							bin_q   <= '0;
							op_q    <= '0;
							k_q     <= '0;
							state_q <= stft_pkg::ST_MAC;
						end else if (fill_q >= stft_pkg::HOP_W'(stft_pkg::N_FFT)) begin
							hop_q <= hop_nxt;
						end
					end
				end
				stft_pkg::ST_MAC: begin
					op_q <= op_q + 1'b1;
					if (op_q[0]) begin
						k_q <= k_q + bin_q[stft_pkg::N_W-1:0];
					end
					if (op_q == {OP_W{1'b1}}) begin
						cnt_q   <= '0;
						state_q <= stft_pkg::ST_DRAIN;
					end
				end
				stft_pkg::ST_DRAIN: begin
					if (cnt_q == 5'd2) begin
						re8_q   <= re8_c;
						im8_q   <= im8_c;
						cnt_q   <= '0;
						state_q <= stft_pkg::ST_SQR;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				stft_pkg::ST_SQR: begin
					case (cnt_q)
						5'd0: begin
							sq_q  <= stft_pkg::SQ_W'(64'(re8_q) * 64'(re8_q));
							cnt_q <= cnt_q + 1'b1;
						end
						5'd1: begin
							sq_q  <= stft_pkg::SQ_W'(64'(im8_q) * 64'(im8_q));
							sum_q <= sq_q;
							cnt_q <= cnt_q + 1'b1;
						end
						default: begin
							v_q     <= sum_q + sq_q;
							res_q   <= '0;
							bit_q   <= stft_pkg::SQ_W'(1) << 60;
							cnt_q   <= '0;
							state_q <= stft_pkg::ST_SQRT;
						end
					endcase
				end
				stft_pkg::ST_SQRT: begin
					if (v_q >= sq_try) begin
						v_q   <= v_q - sq_try;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'd30) begin
						state_q <= stft_pkg::ST_MAG;
					end
				end
				stft_pkg::ST_MAG: begin
					if (m8 < stft_pkg::M8_W'(128)) begin
						ph_re_q <= '0;
						ph_im_q <= '0;
						state_q <= stft_pkg::ST_EMIT;
					end else begin
						part_q  <= 1'b0;
						rem_q   <= stft_pkg::REM_W'(num_re[stft_pkg::NUM_W-1:stft_pkg::QUO_W]);
						quo_q   <= num_re[stft_pkg::QUO_W-1:0];
						cnt_q   <= '0;
						state_q <= stft_pkg::ST_DIV;
					end
				end
				stft_pkg::ST_DIV: begin
					if (div_try >= (stft_pkg::REM_W+1)'(m8)) begin
						rem_q <= stft_pkg::REM_W'(div_try - (stft_pkg::REM_W+1)'(m8));
						quo_q <= {quo_q[stft_pkg::QUO_W-2:0], 1'b1};
					end else begin
						rem_q <= stft_pkg::REM_W'(div_try);
						quo_q <= {quo_q[stft_pkg::QUO_W-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'(stft_pkg::QUO_W - 1)) begin
						state_q <= stft_pkg::ST_FIN;
					end
				end
				stft_pkg::ST_FIN: begin
					if (!part_q) begin
						ph_re_q <= ph_sat;
						part_q  <= 1'b1;
						rem_q   <= stft_pkg::REM_W'(num_im[stft_pkg::NUM_W-1:stft_pkg::QUO_W]);
						quo_q   <= num_im[stft_pkg::QUO_W-1:0];
						cnt_q   <= '0;
						state_q <= stft_pkg::ST_DIV;
					end else begin
						ph_im_q <= ph_sat;
						state_q <= stft_pkg::ST_EMIT;
					end
				end
				stft_pkg::ST_EMIT: begin
					if (out_load) begin
						if (bin_q == stft_pkg::BIN_W'(stft_pkg::LAST_BIN)) begin
							frame_q <= frame_q + 1'b1;
							state_q <= stft_pkg::ST_IDLE;
						end else begin
							bin_q   <= bin_q + 1'b1;
							op_q    <= '0;
							k_q     <= '0;
							state_q <= stft_pkg::ST_MAC;
						end
					end
				end
				default: state_q <= stft_pkg::ST_IDLE;
			endcase
		end
	end

	// output register: hold the beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
			out_data_q  <= '0;
		end else if (out_load) begin
			logic [stft_pkg::M8_W:0] mag_w;
			mag_w = (stft_pkg::M8_W+1)'(m8) + (stft_pkg::M8_W+1)'(128);
			out_valid_q <= 1'b1;
			out_last_q  <= (bin_q == stft_pkg::BIN_W'(stft_pkg::LAST_BIN));
			out_data_q  <= {4'b0, frame_q, ph_im_q, ph_re_q,
				mag_w[stft_pkg::MAG_W+7:8], bin_q};
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	a_last_bin: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tdata[5:0] == stft_pkg::BIN_W'(stft_pkg::LAST_BIN))))
		else $error("tlast does not match final bin");

	a_zero_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[27:6] == '0) |-> (m_tdata[59:28] == '0))
		else $error("phase nonzero on zero magnitude");

	a_idle_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!vld_s1 && !vld_s2))
		else $error("MAC pipeline busy while accepting samples");

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Checks stft_magnitude_phase_core against a behavioral frame DFT predictor.
// Samples stream in with random gaps and result beats leave under random
// back-pressure. Every bin of every completed frame is compared field by field.
// The hop length is swept through its extremes between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb_top;

	typedef struct packed {
		logic [5:0]  bin;
		logic [21:0] mag;
		logic [15:0] ph_re;
		logic [15:0] ph_im;
		logic [15:0] frame;
		logic        last;
	} bin_result_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [stft_pkg::SMP_W-1:0]    s_tdata = '0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [stft_pkg::DATA_W-1:0]   m_tdata;
	logic                          m_tlast;
	logic                          cfg_we = 1'b0;
	logic [stft_pkg::HOP_W-1:0]    cfg_wdata = '0;

	stft_magnitude_phase_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	logic [15:0]   sample_q[$];
	bin_result_t   bins_due[$];
	int            errors = 0;
	bit            sample_taken = 0;
	bit            hold_samples = 0;
	int            send_gap = 0;
	int            sink_stall = 0;

	// predictor state
	longint        cos_tab[64];
	longint        sin_tab[64];
	logic signed [15:0] history[64];
	int            filled, since_frame, wr_ptr;
	logic [15:0]   frame_cnt;
	logic [6:0]    hop;

	function automatic longint q29_mul(longint a, longint b);
		return (a * b + (longint'(1) <<< 28)) >>> 29;
	endfunction

	task automatic build_twiddles();
		longint ang, sq, term_c, term_s, acc_c, acc_s, div_c, div_s;
		int quad, rest;
		for (int k = 0; k < 64; k++) begin
			quad = (4 * k) / 64;
			rest = 4 * k - quad * 64;
			ang = (longint'(1686629713) * rest + 64) / 128;
			sq = q29_mul(ang, ang);
			term_c = longint'(1) <<< 29;
			term_s = ang;
			acc_c = term_c;
			acc_s = ang;
			for (int i = 1; i <= 10; i++) begin
				div_c = (2 * i - 1) * (2 * i);
				div_s = (2 * i) * (2 * i + 1);
				term_c = (q29_mul(term_c, sq) + div_c / 2) / div_c;
				term_s = (q29_mul(term_s, sq) + div_s / 2) / div_s;
				if (i % 2) begin
					acc_c -= term_c;
					acc_s -= term_s;
				end else begin
					acc_c += term_c;
					acc_s += term_s;
				end
			end
			case (quad)
				0: begin cos_tab[k] = acc_c;  sin_tab[k] = acc_s;  end
				1: begin cos_tab[k] = -acc_s; sin_tab[k] = acc_c;  end
				2: begin cos_tab[k] = -acc_c; sin_tab[k] = -acc_s; end
				default: begin cos_tab[k] = acc_s; sin_tab[k] = -acc_c; end
			endcase
		end
	endtask

	function automatic longint to_q8(longint v);
		longint a;
		a = v < 0 ? -v : v;
		a = (a + (longint'(1) <<< 20)) >>> 21;
		return v < 0 ? -a : a;
	endfunction

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = longint'(1) << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic logic [15:0] unit_component(longint v, longint m8);
		longint a, q;
		a = v < 0 ? -v : v;
		q = (a * 32768 + m8 / 2) / m8;
		if (v < 0)
			return q > 32768 ? 16'h8000 : 16'(-q);
		return q > 32767 ? 16'h7fff : 16'(q);
	endfunction

	task automatic emit_spectrum();
		longint x[64];
		longint re, im, re8, im8, m8, mag;
		bin_result_t r;
		for (int n = 0; n < 64; n++) x[n] = history[(wr_ptr + n) % 64];
		for (int f = 0; f <= 32; f++) begin
			re = 0;
			im = 0;
			for (int n = 0; n < 64; n++) begin
				re += x[n] * cos_tab[(f * n) % 64];
				im -= x[n] * sin_tab[(f * n) % 64];
			end
			re8 = to_q8(re);
			im8 = to_q8(im);
			m8 = int_sqrt(re8 * re8 + im8 * im8);
			mag = (m8 + 128) >>> 8;
			r.bin = 6'(f);
			r.mag = 22'(mag);
			r.ph_re = mag == 0 ? 16'd0 : unit_component(re8, m8);
			r.ph_im = mag == 0 ? 16'd0 : unit_component(im8, m8);
			r.frame = frame_cnt;
			r.last = (f == 32);
			bins_due.insert(bins_due.size(), r);
		end
		frame_cnt++;
	endtask

	task automatic take_sample(logic [15:0] s);
		bit fire;
		fire = 0;
		history[wr_ptr] = s;
		wr_ptr = (wr_ptr + 1) % 64;
		if (filled < 64) begin
			filled++;
			if (filled == 64) begin
				fire = 1;
				since_frame = 0;
			end
		end else begin
			since_frame = (since_frame + 1) & 7'h7f;
			if (since_frame >= hop) begin
				fire = 1;
				since_frame = 0;
			end
		end
		if (fire) emit_spectrum();
	endtask

	task automatic check_beat();
		bin_result_t want, got;
		got.bin = m_tdata[5:0];
		got.mag = m_tdata[27:6];
		got.ph_re = m_tdata[43:28];
		got.ph_im = m_tdata[59:44];
		got.frame = m_tdata[75:60];
		got.last = m_tlast;
		if (bins_due.size() == 0) begin
			$display("%0t: unexpected result beat %h", $time, got);
			errors++;
			return;
		end
		want = bins_due.pop_front();
		if (got !== want || m_tdata[79:76] !== 4'd0) begin
			$display("%0t: mismatch expected bin=%0d mag=%0d re=%h im=%h frm=%0d last=%b",
				$time, want.bin, want.mag, want.ph_re, want.ph_im, want.frame, want.last);
			$display("%0t:          actual bin=%0d mag=%0d re=%h im=%h frm=%0d last=%b pad=%h",
				$time, got.bin, got.mag, got.ph_re, got.ph_im, got.frame, got.last,
				m_tdata[79:76]);
			errors++;
		end
	endtask

	// monitor: predictor update and result check
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) hop = cfg_wdata;
			if (s_tvalid && s_tready) begin
				take_sample(s_tdata);
				sample_taken = 1;
			end
			if (m_tvalid && m_tready) check_beat();
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// sample driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_tvalid && !sample_taken) begin
				// hold the beat until accepted
			end else if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (sample_q.size() != 0 && !hold_samples) begin
				s_tdata <= sample_q.pop_front();
				s_tvalid <= 1'b1;
				send_gap = pick_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
			sample_taken = 0;
		end
	end

	// result sink with random stalls
	always @(negedge clk) begin
		if (arst_n) begin
			if (sink_stall > 0) begin
				sink_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				sink_stall = pick_gap();
			end
		end
	end

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'($signed($urandom_range(0, 15)) - 8);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic queue_sample(logic [15:0] v);
		sample_q.insert(sample_q.size(), v);
	endtask

	task automatic queue_random(int n);
		repeat (n) queue_sample(rand_sample());
	endtask

	task automatic wait_quiet();
		wait (sample_q.size() == 0 && !s_tvalid && bins_due.size() == 0);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_hop(logic [6:0] v);
		wait_quiet();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		build_twiddles();
		filled = 0;
		since_frame = 0;
		wr_ptr = 0;
		frame_cnt = '0;
		hop = 7'd16;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// constant full-scale frame: every bin but DC has zero magnitude
		repeat (64) queue_sample(16'h7fff);
		repeat (16) queue_sample(16'h8000);
		for (int i = 0; i < 16; i++) queue_sample(i % 2 ? 16'h8000 : 16'h7fff);
		repeat (8) queue_sample(16'h0000);
		for (int i = 0; i < 8; i++) queue_sample(i % 2 ? 16'hffff : 16'h0001);
		queue_random(8);

		// drain the results before sending on
		wait (sample_q.size() < 10);
		hold_samples = 1;
		wait (bins_due.size() == 0);
		repeat (5) @(negedge clk);
		hold_samples = 0;

		write_hop(7'd0);
		queue_random(8);
		write_hop(7'd1);
		queue_random(6);
		write_hop(7'd127);
		queue_random(130);
		write_hop(7'd64);
		queue_random(66);
		repeat (2) begin
			write_hop(7'($urandom_range(2, 8)));
			queue_random($urandom_range(4, 8));
		end
		wait_quiet();
		repeat (100) @(negedge clk);
		if (errors == 0 && bins_due.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#200_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/stft_pkg.sv
rtl/core/stft_magnitude_phase_core.sv
sim/tb_top.sv
